// ===== design/bps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search package
// Shared types and constants for the byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Pattern register layout is fixed: two 64-bit words of bytes.
    localparam int PATTERN_BYTES = 16;
    localparam int LEN_WIDTH     = 5;
    localparam int RESULT_WIDTH  = 32;
    localparam int APB_DATA      = 64;
    localparam int APB_ADDR      = 5;

    // Depth of the queue between the front and back stages.
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        REG_PAT_LO  = 2'd0,
        REG_PAT_HI  = 2'd1,
        REG_PAT_LEN = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [63:0]          pat_lo;
        logic [63:0]          pat_hi;
        logic [LEN_WIDTH-1:0] len;
    } t_cfg;

endpackage

// ===== design/bps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search channels
// Valid/ready channels for the byte stream and for the search result.
// ----------------------------------------------------------------------------
interface bps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bps_out_if import bps_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [RESULT_WIDTH-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ===== design/byte_pattern_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search
// Leftmost search for a programmable byte pattern in a marked byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle unless stalled. The front stage shifts each
// byte into a window of the last MAX_PATTERN bytes and compares the whole
// window with the pattern in the same cycle, so the window compare sets the
// rate. Each byte's hit flag and candidate offset pass through a two-entry
// queue to the back stage, which keeps the first hit of the buffer. The result
// enters the output register when its last byte's entry leaves the queue and
// is held there while the front keeps taking bytes of the next buffer. A
// stalled result stalls the front only once the queue is full. A pattern length
// of zero or above MAX_PATTERN never matches; the byte count saturates.
// ----------------------------------------------------------------------------
module byte_pattern_search import bps_pkg::*; #(
    parameter int MAX_PATTERN  = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_ADDR-1:0] paddr,
    input  logic [APB_DATA-1:0] pwdata,
    output logic [APB_DATA-1:0] prdata,
    output logic                pready,
    bps_in_if.sink              i_in,
    bps_out_if.source           o_out
);

    localparam int Q_WIDTH = OFFSET_WIDTH + 2;

    t_cfg               w_cfg;
    logic               w_q_push, w_q_ready, w_q_pop, w_q_valid;
    logic [Q_WIDTH-1:0] w_q_wdata, w_q_rdata;

    bps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bps_front #(
        .MAX_PATTERN  (MAX_PATTERN),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_in.valid),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_ready     (i_in.ready),
        .i_q_ready   (w_q_ready),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_wdata)
    );

    bps_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    bps_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_data       (w_q_rdata),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_found        (o_out.found),
        .o_match_offset (o_out.match_offset)
    );

endmodule

// ===== design/bps_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search configuration registers
// APB register file holding the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
module bps_cfg import bps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_ADDR-1:0] paddr,
    input  logic [APB_DATA-1:0] pwdata,
    output logic [APB_DATA-1:0] prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR-1:3]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAT_LO:  r_cfg.pat_lo <= pwdata;
                REG_PAT_HI:  r_cfg.pat_hi <= pwdata;
                REG_PAT_LEN: r_cfg.len    <= pwdata[LEN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_LO:  prdata = r_cfg.pat_lo;
            REG_PAT_HI:  prdata = r_cfg.pat_hi;
            REG_PAT_LEN: prdata = APB_DATA'(r_cfg.len);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/bps_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search queue
// Small register FIFO between the classifying front and the result back end.
// ----------------------------------------------------------------------------
module bps_queue import bps_pkg::*; #(
    parameter int WIDTH = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/bps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search front end
// Shifts each byte into the window, counts bytes and flags pattern hits.
// ----------------------------------------------------------------------------
module bps_front import bps_pkg::*; #(
    parameter int MAX_PATTERN  = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_last_byte,
    output logic                    o_ready,
    input  logic                    i_q_ready,
    output logic                    o_q_push,
    output logic [OFFSET_WIDTH+1:0] o_q_data
);

    logic [7:0]              r_window [MAX_PATTERN];
    logic [7:0]              n_window [MAX_PATTERN];
    logic [OFFSET_WIDTH-1:0] r_count, n_count;
    logic [7:0]              w_pat [PATTERN_BYTES];
    logic [MAX_PATTERN-1:0]  w_pos_ok;
    logic                    w_len_ok;
    logic                    w_hit;
    logic [OFFSET_WIDTH-1:0] w_offset;
    logic                    w_accept;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid & i_q_ready;

    always_comb begin
        for (int i = 0; i < PATTERN_BYTES / 2; i++) begin
            w_pat[i]                     = i_cfg.pat_lo[8*i +: 8];
            w_pat[i + PATTERN_BYTES / 2] = i_cfg.pat_hi[8*i +: 8];
        end
    end

    always_comb begin
        n_window[0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    assign n_count = (r_count == '1) ? r_count : r_count + 1'b1;

    // Window entry j (newest first) lines up with pattern byte len-1-j.
    always_comb begin
        logic [LEN_WIDTH-1:0] idx;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            idx         = i_cfg.len - LEN_WIDTH'(1) - LEN_WIDTH'(j);
            w_pos_ok[j] = (LEN_WIDTH'(j) >= i_cfg.len) ||
                          (n_window[j] == w_pat[idx[3:0]]);
        end
    end

    assign w_len_ok = (i_cfg.len != '0) && (i_cfg.len <= LEN_WIDTH'(MAX_PATTERN));
    assign w_hit    = w_len_ok && (n_count >= OFFSET_WIDTH'(i_cfg.len)) && (&w_pos_ok);
    assign w_offset = n_count - OFFSET_WIDTH'(i_cfg.len);

    assign o_q_push = w_accept;
    assign o_q_data = {i_last_byte, w_hit, w_offset};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            // restart the count for the next buffer after its last byte
            r_count <= i_last_byte ? '0 : n_count;
        end
    end

endmodule

// ===== design/bps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search back end
// Keeps the leftmost hit of the buffer and issues the result on its last byte.
// ----------------------------------------------------------------------------
module bps_back import bps_pkg::*; #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  logic [OFFSET_WIDTH+1:0] i_q_data,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_found,
    output logic [RESULT_WIDTH-1:0] o_match_offset
);

    logic                    w_last, w_hit;
    logic [OFFSET_WIDTH-1:0] w_offset;
    logic                    r_seen;
    logic [OFFSET_WIDTH-1:0] r_first;
    logic                    r_out_valid;
    logic                    r_found;
    logic [RESULT_WIDTH-1:0] r_match_offset;
    logic                    w_out_free;
    logic                    w_found;
    logic [OFFSET_WIDTH-1:0] w_sel_offset;

    assign {w_last, w_hit, w_offset} = i_q_data;

    assign w_out_free = !r_out_valid || i_ready;
    // hold a last-byte entry until the output register can take the result
    assign o_q_pop    = i_q_valid && (!w_last || w_out_free);

    assign w_found      = r_seen || w_hit;
    assign w_sel_offset = r_seen ? r_first : (w_hit ? w_offset : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_first <= '0;
        end else if (o_q_pop) begin
            if (w_last) begin
                r_seen  <= 1'b0;
                r_first <= '0;
            end else if (!r_seen && w_hit) begin
                r_seen  <= 1'b1;
                r_first <= w_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop && w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && w_last) begin
            r_found        <= w_found;
            r_match_offset <= RESULT_WIDTH'(w_sel_offset);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_match_offset;

endmodule

// ===== design/bps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search checker
// Port-level assertions on the result channel and the register port.
// ----------------------------------------------------------------------------
module bps_checker import bps_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_psel,
    input logic                    i_pwrite,
    input logic [APB_ADDR-1:0]     i_paddr,
    input logic [APB_DATA-1:0]     i_prdata,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic                    i_found,
    input logic [RESULT_WIDTH-1:0] i_match_offset
);

    // a miss always reports offset zero
    a_miss_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_match_offset == '0))
        else $error("result without match carries a nonzero offset");

    // the length register reads back no more than its five bits
    a_len_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && !i_pwrite && (t_reg_idx'(i_paddr[APB_ADDR-1:3]) == REG_PAT_LEN))
        |-> (i_prdata[APB_DATA-1:LEN_WIDTH] == '0))
        else $error("pattern length readback has upper bits set");

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_found) && $stable(i_match_offset)))
        else $error("result changed while stalled");

endmodule

bind byte_pattern_search bps_checker u_bps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_psel         (psel),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_prdata       (prdata),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_found        (o_out.found),
    .i_match_offset (o_out.match_offset)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search testbench
// Streams marked byte buffers through the search block over valid/ready
// channels, programs the pattern over APB between buffers, and checks every
// found flag and match offset against a cycle-free model of the leftmost
// window search kept in this module.
// ----------------------------------------------------------------------------
module tb_top;
    import bps_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 400;
    localparam int SETTLE      = 8;
    localparam int PHASE_ITEMS = 185;
    localparam int NUM_PHASES  = 9;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct {
        logic                    found;
        logic [RESULT_WIDTH-1:0] offset;
    } search_result_t;

    logic                i_clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_ADDR-1:0] paddr;
    logic [APB_DATA-1:0] pwdata;
    logic [APB_DATA-1:0] prdata;
    logic                pready;

    bps_in_if  byte_ch ();
    bps_out_if result_ch ();

    byte_pattern_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Programmed pattern as seen by the search model
    logic [8*PATTERN_BYTES-1:0] cfg_pat;
    logic [LEN_WIDTH-1:0]       cfg_len;

    // Search model state for the buffer in flight
    logic [7:0]              win [PATTERN_BYTES];
    logic [RESULT_WIDTH-1:0] seen_count;
    logic                    hit_flag;
    logic [RESULT_WIDTH-1:0] hit_offset;

    stream_byte_t   byte_stream [$];
    search_result_t search_verdicts [$];
    stream_byte_t   tx_byte;
    search_result_t want;

    bit          byte_taken = 1'b0;
    int          mismatches = 0;
    int          items_queued = 0;
    int          cycle_count;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          stall_requests = 0;
    int          stall_served = 0;
    int          stall_left = 0;

    task automatic clear_buffer();
        for (int k = 0; k < PATTERN_BYTES; k++) win[k] = 8'h00;
        seen_count = '0;
        hit_flag   = 1'b0;
        hit_offset = '0;
    endtask

    // Shift one byte in, look for the first full match, close the buffer on last
    task automatic scan_byte(input logic [7:0] b, input logic last);
        int unsigned    n;
        bit             ok;
        search_result_t r;
        for (int k = PATTERN_BYTES - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = b;
        if (seen_count != '1) seen_count = seen_count + 1'b1;
        n = cfg_len;
        if (!hit_flag && n > 0 && n <= PATTERN_BYTES && seen_count >= n) begin
            ok = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (win[n-1-i] != cfg_pat[8*i +: 8]) ok = 1'b0;
            end
            if (ok) begin
                hit_flag   = 1'b1;
                hit_offset = seen_count - RESULT_WIDTH'(n);
            end
        end
        if (last) begin
            r.found  = hit_flag;
            r.offset = hit_flag ? hit_offset : '0;
            search_verdicts.push_back(r);
            clear_buffer();
        end
    endtask

    task automatic apb_write_reg(input t_reg_idx idx, input logic [APB_DATA-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR'(int'(idx) * 8);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_PAT_LO:  cfg_pat[63:0]   = value[63:0];
            REG_PAT_HI:  cfg_pat[127:64] = value[63:0];
            REG_PAT_LEN: cfg_len         = value[LEN_WIDTH-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [LEN_WIDTH-1:0] len);
        apb_write_reg(REG_PAT_LO, APB_DATA'(lo));
        apb_write_reg(REG_PAT_HI, APB_DATA'(hi));
        apb_write_reg(REG_PAT_LEN, APB_DATA'(len));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        stream_byte_t s;
        s.data = b;
        s.last = last;
        byte_stream.push_back(s);
        items_queued++;
    endtask

    // Hold the sender until every byte is in and every result is out
    task automatic drain_all();
        while (byte_stream.size() != 0 || byte_ch.valid || search_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // One buffer: mostly planted matches over random or pattern-like bytes,
    // the rest broken prefixes, plain noise and buffers shorter than the pattern
    task automatic gen_buffer();
        int         plen;
        int         n;
        int         pos;
        int         part;
        int         copies;
        int         cut;
        int         idx;
        bit         narrow;
        logic [7:0] body [];
        plen = (int'(cfg_len) > PATTERN_BYTES) ? PATTERN_BYTES : int'(cfg_len);
        case ($urandom_range(0, 9))
            0: n = $urandom_range(1, (plen > 1) ? plen : 2);
            1: n = $urandom_range(30, 60);
            default: n = plen + $urandom_range(0, 12);
        endcase
        if (n < 1) n = 1;
        body   = new[n];
        narrow = ($urandom_range(0, 1) == 1) && (plen > 0);
        for (int k = 0; k < n; k++) begin
            if (narrow && $urandom_range(0, 7) != 0) begin
                idx     = $urandom_range(0, plen - 1);
                body[k] = cfg_pat[8*idx +: 8];
            end else begin
                body[k] = 8'($urandom_range(0, 255));
            end
        end
        part = $urandom_range(0, 9);
        if (plen > 0 && n >= plen && part < 7) begin
            copies = (part < 2) ? 2 : 1;
            for (int c = 0; c < copies; c++) begin
                pos = $urandom_range(0, n - plen);
                for (int k = 0; k < plen; k++) body[pos+k] = cfg_pat[8*k +: 8];
            end
        end else if (plen > 1 && part < 9) begin
            cut = $urandom_range(1, plen - 1);
            if (n >= cut) begin
                pos = $urandom_range(0, n - cut);
                for (int k = 0; k < cut; k++) body[pos+k] = cfg_pat[8*k +: 8];
            end
        end
        for (int k = 0; k < n; k++) push_byte(body[k], k == n - 1);
    endtask

    // Byte driver: advance on a completed transaction, else hold
    always @(negedge i_clk) begin
        if (rst_n) begin
            if (!byte_ch.valid || byte_taken) begin
                if (byte_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    tx_byte = byte_stream.pop_front();
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= tx_byte.data;
                    byte_ch.last_byte <= tx_byte.last;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (rst_n) begin
            if (stall_served != stall_requests) begin
                stall_served    <= stall_requests;
                stall_left      <= LONG_STALL;
                result_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left      <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: feed accepted bytes to the model, check accepted results
    always @(posedge i_clk) begin
        byte_taken <= byte_ch.valid && byte_ch.ready;
        if (rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                scan_byte(byte_ch.data_byte, byte_ch.last_byte);
            if (result_ch.valid && result_ch.ready) begin
                if (search_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual found %0b offset %0d",
                             $time, result_ch.found, result_ch.match_offset);
                    mismatches++;
                end else begin
                    want = search_verdicts.pop_front();
                    if (result_ch.found !== want.found) begin
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want.found, result_ch.found);
                        mismatches++;
                    end
                    if (result_ch.match_offset !== want.offset) begin
                        $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                                 $time, want.offset, result_ch.match_offset);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [7:0]           dup_seq [12] = '{8'hFF, 8'hDE, 8'hAD, 8'hDE, 8'hAD, 8'hBE,
                                               8'hEF, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        logic [LEN_WIDTH-1:0] phase_len [NUM_PHASES] = '{5'd3, 5'd16, 5'd1, 5'd8, 5'd0,
                                                         5'd12, 5'd16, 5'd31, 5'd5};
        logic [63:0]          lo;
        logic [63:0]          hi;
        int                   goal;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'h00;
        byte_ch.last_byte   = 1'b0;
        result_ch.ready     = 1'b0;
        cfg_pat             = '0;
        cfg_len             = '0;
        clear_buffer();
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 50;

        // Four-byte pattern: short buffer, exact buffer, leftmost of two hits
        set_pattern(64'h0000_0000_EFBE_ADDE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd4);
        push_byte(8'h00, 1'b1);
        push_byte(8'hDE, 1'b0);
        push_byte(8'hAD, 1'b0);
        push_byte(8'hBE, 1'b0);
        push_byte(8'hEF, 1'b1);
        for (int k = 0; k < 12; k++) push_byte(dup_seq[k], k == 11);
        drain_all();

        // Empty pattern over bytes that a zero pattern would match
        set_pattern(64'h0, 64'h0, 5'd0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        drain_all();

        // Length beyond the window never matches
        apb_write_reg(REG_PAT_LEN, APB_DATA'(5'd31));
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        drain_all();

        // Single-byte pattern on a single-byte buffer
        set_pattern(64'h0000_0000_0000_00FF, 64'h0, 5'd1);
        push_byte(8'hFF, 1'b1);
        drain_all();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 50;
            end else if (p < 6) begin
                send_idle_pct = 50;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (p == 1) begin
                lo = '1;
                hi = '1;
            end else if (p == 3) begin
                lo = '0;
            end
            set_pattern(lo, hi, phase_len[p]);
            if (p == 6) begin
                // block the result side for a long stretch while bytes keep coming
                @(posedge i_clk);
                stall_requests++;
            end
            goal = items_queued + PHASE_ITEMS;
            while (items_queued < goal) gen_buffer();
            drain_all();
        end

        if (mismatches == 0 && search_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
